### design/spfd_pkg.sv
// Shared types, constants and status codes for the sensor pulse frame decoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package spfd_pkg;

  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 4;

  localparam logic [BYTE_W-1:0] FRAC_LIMIT = 8'd9;
  localparam logic [CNT_W-1:0]  LAST_PULSE = CNT_W'(FRAME_BITS - 1);

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_ONE_MIN  = 2'd0;
  localparam logic [1:0] REG_ONE_MAX  = 2'd1;
  localparam logic [1:0] REG_ZERO_MIN = 2'd2;
  localparam logic [1:0] REG_ZERO_MAX = 2'd3;

  // Reset values of the window registers.
  localparam logic [BYTE_W-1:0] ONE_MIN_RST  = 8'd60;
  localparam logic [BYTE_W-1:0] ONE_MAX_RST  = 8'd79;
  localparam logic [BYTE_W-1:0] ZERO_MIN_RST = 8'd23;
  localparam logic [BYTE_W-1:0] ZERO_MAX_RST = 8'd28;

  // Frame status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CKSUM   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] one_min;
    logic [BYTE_W-1:0] one_max;
    logic [BYTE_W-1:0] zero_min;
    logic [BYTE_W-1:0] zero_max;
  } win_cfg_t;

  // A completed frame as it leaves the bit accumulator.
  typedef struct packed {
    logic                  last;
    logic                  pulse_err;
    logic [FRAME_BITS-1:0] bits;
  } frame_t;

endpackage

`default_nettype wire

### design/spfd_in_if.sv
// Input channel of the pulse frame decoder: one pulse width per word.
// Depends on spfd_pkg.
`default_nettype none

interface spfd_in_if;
  import spfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pulse_us;

  modport source (output valid, output pulse_us, input ready);
  modport sink   (input valid, input pulse_us, output ready);
endinterface

`default_nettype wire

### design/spfd_out_if.sv
// Result channel of the pulse frame decoder: five frame bytes and a status per word.
// Depends on spfd_pkg.
`default_nettype none

interface spfd_out_if;
  import spfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   humidity_int;
  logic [BYTE_W-1:0]   humidity_frac;
  logic [BYTE_W-1:0]   temp_int;
  logic [BYTE_W-1:0]   temp_frac;
  logic [BYTE_W-1:0]   check_byte;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output humidity_int, output humidity_frac, output temp_int,
                  output temp_frac, output check_byte, output status, input ready);
  modport sink   (input valid, input humidity_int, input humidity_frac, input temp_int,
                  input temp_frac, input check_byte, input status, output ready);
endinterface

`default_nettype wire

### design/spfd_cfg_regs.sv
// APB register file holding the bounds of the two pulse classification windows.
// Depends on spfd_pkg.
`default_nettype none

module spfd_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spfd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [spfd_pkg::APB_DW-1:0]  pwdata,
  output logic      [spfd_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output spfd_pkg::win_cfg_t                cfg
);
  import spfd_pkg::*;

  win_cfg_t   cfg_r;
  win_cfg_t   cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ONE_MIN:  cfg_nxt.one_min  = pwdata[BYTE_W-1:0];
        REG_ONE_MAX:  cfg_nxt.one_max  = pwdata[BYTE_W-1:0];
        REG_ZERO_MIN: cfg_nxt.zero_min = pwdata[BYTE_W-1:0];
        REG_ZERO_MAX: cfg_nxt.zero_max = pwdata[BYTE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_min  <= ONE_MIN_RST;
      cfg_r.one_max  <= ONE_MAX_RST;
      cfg_r.zero_min <= ZERO_MIN_RST;
      cfg_r.zero_max <= ZERO_MAX_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ONE_MIN:  prdata[BYTE_W-1:0] = cfg_r.one_min;
      REG_ONE_MAX:  prdata[BYTE_W-1:0] = cfg_r.one_max;
      REG_ZERO_MIN: prdata[BYTE_W-1:0] = cfg_r.zero_min;
      REG_ZERO_MAX: prdata[BYTE_W-1:0] = cfg_r.zero_max;
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/spfd_bit_acc.sv
// Classifies each pulse width against the windows and shifts the bit into the frame.
// Depends on spfd_pkg.
`default_nettype none

module spfd_bit_acc (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [spfd_pkg::BYTE_W-1:0]   pulse_us,
  input  wire spfd_pkg::win_cfg_t            cfg,
  output spfd_pkg::frame_t                   frame
);
  import spfd_pkg::*;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic                  err_r, err_nxt;
  logic                  is_one, is_zero, last;
  logic [FRAME_BITS-1:0] shifted;
  logic                  err_seen;

  // The one window takes priority where the two overlap.
  assign is_one   = (pulse_us >= cfg.one_min) && (pulse_us <= cfg.one_max);
  assign is_zero  = (pulse_us >= cfg.zero_min) && (pulse_us <= cfg.zero_max);
  assign shifted  = {shift_r[FRAME_BITS-2:0], is_one};
  assign err_seen = err_r | ~(is_one | is_zero);
  assign last     = (count_r == LAST_PULSE);

  always_comb begin
    count_nxt = count_r;
    shift_nxt = shift_r;
    err_nxt   = err_r;
    if (step) begin
      if (last) begin
        count_nxt = '0;
        shift_nxt = '0;
        err_nxt   = 1'b0;
      end else begin
        count_nxt = count_r + 1'b1;
        shift_nxt = shifted;
        err_nxt   = err_seen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      shift_r <= '0;
      err_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      err_r   <= err_nxt;
    end
  end

  assign frame.last      = last;
  assign frame.pulse_err = err_seen;
  assign frame.bits      = shifted;

endmodule

`default_nettype wire

### design/spfd_frame_chk.sv
// Checks a completed frame and holds the result word until the sink takes it.
// Depends on spfd_pkg and spfd_out_if.
`default_nettype none

module spfd_frame_chk (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire spfd_pkg::frame_t  frame,
  output logic                   busy,
  spfd_out_if.source             out_ch
);
  import spfd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   b0, b1, b2, b3, b4;
  logic [BYTE_W-1:0]   sum;
  logic                invalid;
  logic [BYTE_W-1:0]   hi_r, hf_r, ti_r, tf_r, ck_r;
  logic [STATUS_W-1:0] status_r;

  assign b0 = frame.bits[39:32];
  assign b1 = frame.bits[31:24];
  assign b2 = frame.bits[23:16];
  assign b3 = frame.bits[15:8];
  assign b4 = frame.bits[7:0];

  assign sum     = b0 + b1 + b2 + b3;
  assign invalid = frame.pulse_err | (b1 > FRAC_LIMIT) | (b3 > FRAC_LIMIT);

  always_comb begin
    valid_nxt = valid_r;
    if (out_ch.ready) valid_nxt = 1'b0;
    if (load)         valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (invalid) begin
        hi_r     <= '0;
        hf_r     <= '0;
        ti_r     <= '0;
        tf_r     <= '0;
        ck_r     <= '0;
        status_r <= STATUS_INVALID;
      end else begin
        hi_r     <= b0;
        hf_r     <= b1;
        ti_r     <= b2;
        tf_r     <= b3;
        ck_r     <= b4;
        status_r <= (sum == b4) ? STATUS_OK : STATUS_CKSUM;
      end
    end
  end

  // The result register can take a new word when empty or being emptied this cycle.
  assign busy = valid_r & ~out_ch.ready;

  assign out_ch.valid         = valid_r;
  assign out_ch.humidity_int  = hi_r;
  assign out_ch.humidity_frac = hf_r;
  assign out_ch.temp_int      = ti_r;
  assign out_ch.temp_frac     = tf_r;
  assign out_ch.check_byte    = ck_r;
  assign out_ch.status        = status_r;

endmodule

`default_nettype wire

### design/sensor_pulse_frame_decoder_unit.sv
// Top level of the sensor pulse frame decoder: input register, bit accumulator,
// frame checker with result register, and the APB window registers. Depends on spfd_pkg.
//
//   channel  | direction | word / access
//   ---------+-----------+-----------------------------------------------------
//   in_ch    | sink      | pulse_us, one high-pulse width per word
//   out_ch   | source    | five frame bytes and status, one word per 40 pulses
//   APB      | slave     | four 8-bit window registers at byte offsets 0,4,8,12
//
// One word is taken per cycle while no pulse is held back: a pulse is registered
// in the input register, is classified and shifted in, and on the 40th pulse
// the checked frame is loaded into the result register. Only the 40th pulse of
// a frame waits when the result register is still full; other pulses flow on.
// Reset is synchronous and active low and clears the frame state and restores
// the window defaults.
`default_nettype none

module sensor_pulse_frame_decoder_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  spfd_in_if.sink                           in_ch,
  spfd_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spfd_pkg::APB_AW-1:0]  paddr,
  input  wire logic [spfd_pkg::APB_DW-1:0]  pwdata,
  output logic      [spfd_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);
  import spfd_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] pulse_r;
  logic              advance;
  logic              out_busy;
  win_cfg_t          cfg;
  frame_t            frame;

  spfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held pulse moves on unless it closes a frame and the result register is occupied.
  assign advance      = in_vld_r & ~(frame.last & out_busy);
  assign in_ch.ready  = ~in_vld_r | advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (advance)                  in_vld_nxt = 1'b0;
    if (in_ch.valid & in_ch.ready) in_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid & in_ch.ready) pulse_r <= in_ch.pulse_us;
  end

  spfd_bit_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .pulse_us (pulse_r),
    .cfg      (cfg),
    .frame    (frame)
  );

  spfd_frame_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (advance & frame.last),
    .frame  (frame),
    .busy   (out_busy),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
